// ----- src/jrci_pkg.sv -----
`default_nettype none

package jrci_pkg;

	// Table geometry and fixed-point formats.
	localparam int TABLE_POINTS = 12;
	localparam int NUM_CURVES   = 3;
	localparam int FRAC_BITS    = 14;
	localparam int GAIN_FRAC    = 12;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 16;
	localparam int SEG_W    = 4;
	localparam int CURVE_W  = 2;
	localparam int Y_W      = 15;
	localparam int DY_W     = 12;
	localparam int OFF_W    = 11;
	localparam int RECIP_W  = 20;
	localparam int PROD1_W  = DY_W + OFF_W;
	localparam int PROD2_W  = PROD1_W + RECIP_W;
	localparam int GAIN_W   = 16;
	localparam int SCALED_W = 2 * GAIN_W;
	localparam int ROUNDED_W = SCALED_W - GAIN_FRAC;

	// Breakpoints in Q.14, thousandths rounded to nearest.
	localparam logic [MAG_W-1:0] BP_FIX [TABLE_POINTS] = '{
		16'd0, 16'd492, 16'd1638, 16'd3277, 16'd4915, 16'd6554,
		16'd8192, 16'd9830, 16'd11469, 16'd13107, 16'd14746, 16'd16384
	};

	// Curve values in Q.14, one row per curve.
	localparam logic [Y_W-1:0] CURVE_FIX [NUM_CURVES][TABLE_POINTS] = '{
		'{15'd0, 15'd0, 15'd983, 15'd2130, 15'd4096, 15'd6062,
		  15'd7864, 15'd9503, 15'd10977, 15'd12288, 15'd14418, 15'd16384},
		'{15'd0, 15'd0, 15'd983, 15'd2294, 15'd3932, 15'd5734,
		  15'd7700, 15'd9830, 15'd12124, 15'd14254, 15'd15729, 15'd16384},
		'{15'd0, 15'd0, 15'd164, 15'd655, 15'd1475, 15'd2621,
		  15'd4096, 15'd5898, 15'd8028, 15'd10486, 15'd13271, 15'd16384}
	};

	// Rounded 2^28 / segment width, indexed by the segment's upper point.
	localparam logic [RECIP_W-1:0] RECIP_FIX [TABLE_POINTS] = '{
		20'd0, 20'd545601, 20'd234237, 20'd163780, 20'd163880, 20'd163780,
		20'd163880, 20'd163880, 20'd163780, 20'd163880, 20'd163780, 20'd163880
	};

	typedef enum logic [0:0] {
		REG_CURVE_SELECT = 1'b0,
		REG_GAIN         = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                     ok;
		logic [CURVE_W-1:0]       idx;
		logic signed [GAIN_W-1:0] gain;
	} cfg_t;

	typedef struct packed {
		logic             neg;
		logic             over;
		logic [SEG_W-1:0] seg;
		logic [OFF_W-1:0] off;
		logic [Y_W-1:0]   y0;
		logic [DY_W-1:0]  dy;
	} front_t;

	typedef struct packed {
		logic           neg;
		logic [Y_W-1:0] y;
	} interp_t;

endpackage

`default_nettype wire

// ----- src/joystick_response_curve_interp_unit.sv -----
`default_nettype none

// Nine register stages lie between an accepted input word and its result on
// m_tdata, the first one loaded at the accepting edge; each has a valid bit.
// Throughput: one word per clock while the output is not stalled.
// Each stage refills as soon as its word moves on, so a stalled output only
// backs up the stages behind it. Reset is asynchronous, active low: it empties
// the pipeline and sets curve_select to 1 and gain to 1.0 (4096).
module joystick_response_curve_interp_unit import jrci_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write port.
	input  logic                cfg_we,
	input  logic [0:0]          cfg_addr,
	input  logic [GAIN_W-1:0]   cfg_wdata,
	// Input stream.
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] stick_sample
	// Output stream.
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_tdata    // [15:0] shaped_value
);

	logic [CURVE_W-1:0]       curve_select_q;
	logic signed [GAIN_W-1:0] gain_q;
	cfg_t                     cfg;

	logic    front_valid, front_ready;
	front_t  front_data;
	logic    interp_valid, interp_ready;
	interp_t interp_data;

	// Configuration registers. The user must keep writes to times when the pipeline
	// is empty; the block itself does not enforce this. Every stage reads them directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_select_q <= CURVE_W'(1);
			gain_q         <= GAIN_W'(4096);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_CURVE_SELECT: curve_select_q <= cfg_wdata[CURVE_W-1:0];
				REG_GAIN:         gain_q         <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	// Curve numbers start at 1; zero or any number past the last curve
	// selects none, and the output is then forced to zero.
	always_comb begin
		cfg.ok   = (curve_select_q != '0) && (curve_select_q <= CURVE_W'(NUM_CURVES));
		cfg.idx  = cfg.ok ? curve_select_q - 1'b1 : '0;
		cfg.gain = gain_q;
	end

	// Stages 1-3: sample magnitude, segment search, breakpoint and
	// curve lookup.
	jrci_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sample    (s_tdata),
		.cfg       (cfg),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_data  (front_data)
	);

	// Stages 4-6: dy * dx offset, times the segment reciprocal, then the
	// rounded add onto the segment's base value, or the curve top past the last breakpoint.
	jrci_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.cfg       (cfg),
		.out_valid (interp_valid),
		.out_ready (interp_ready),
		.out_data  (interp_data)
	);

	// Stages 7-9: signed gain, rounding, clamp to the curve top, sign.
	jrci_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (interp_valid),
		.in_ready  (interp_ready),
		.in_data   (interp_data),
		.cfg       (cfg),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

`ifndef ASSERT_OFF
	// Input back-pressure only ever comes from a held output word.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled while the output was free");

	// Results stay within plus or minus full scale.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= $signed(SAMPLE_W'(1 << FRAC_BITS))) &&
			($signed(m_tdata) >= -$signed(SAMPLE_W'(1 << FRAC_BITS))))
		else $error("result outside full scale");
`endif

endmodule

`default_nettype wire

// ----- src/jrci_front.sv -----
`default_nettype none

// Magnitude, segment search and table lookup: stages 1 to 3.
module jrci_front import jrci_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	input  cfg_t                cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output front_t              out_data
);

	logic ld_s1, ld_s2, ld_s3;
	logic v_s1, v_s2, v_s3;

	logic             neg_s1;
	logic [MAG_W-1:0] mag_s1;
	logic             neg_s2;
	logic             over_s2;
	logic [SEG_W-1:0] seg_s2;
	logic [MAG_W-1:0] mag_s2;
	front_t           data_s3;

	logic [MAG_W-1:0] mag_c;
	logic [SEG_W-1:0] seg_c;
	logic [SEG_W-1:0] seg_lo;
	logic [MAG_W-1:0] off_full;
	logic [Y_W-1:0]   y0_c;
	logic [Y_W-1:0]   y1_c;
	logic [Y_W-1:0]   dy_full;

	// A stage loads when it is empty or its content moves on.
	assign ld_s3    = !v_s3 || out_ready;
	assign ld_s2    = !v_s2 || ld_s3;
	assign ld_s1    = !v_s1 || ld_s2;
	assign in_ready = ld_s1;

	always_comb begin
		mag_c = sample[SAMPLE_W-1] ? MAG_W'(~sample + 1'b1) : MAG_W'(sample);
	end

	// Lowest breakpoint above the magnitude; the last segment otherwise.
	always_comb begin
		seg_c = SEG_W'(TABLE_POINTS - 1);
		for (int k = TABLE_POINTS - 2; k >= 1; k--) begin
			if (mag_s1 < BP_FIX[k]) begin
				seg_c = SEG_W'(k);
			end
		end
	end

	always_comb begin
		seg_lo   = seg_s2 - 1'b1;
		off_full = mag_s2 - BP_FIX[seg_lo];
		y0_c     = CURVE_FIX[cfg.idx][seg_lo];
		y1_c     = CURVE_FIX[cfg.idx][seg_s2];
		dy_full  = y1_c - y0_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ld_s1) begin
				v_s1 <= in_valid;
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
			if (ld_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			neg_s1 <= sample[SAMPLE_W-1];
			mag_s1 <= mag_c;
		end
		if (ld_s2) begin
			neg_s2  <= neg_s1;
			over_s2 <= mag_s1 > BP_FIX[TABLE_POINTS-1];
			seg_s2  <= seg_c;
			mag_s2  <= mag_s1;
		end
		if (ld_s3) begin
			data_s3.neg  <= neg_s2;
			data_s3.over <= over_s2;
			data_s3.seg  <= seg_s2;
			data_s3.off  <= off_full[OFF_W-1:0];
			data_s3.y0   <= y0_c;
			data_s3.dy   <= dy_full[DY_W-1:0];
		end
	end

	assign out_valid = v_s3;
	assign out_data  = data_s3;

`ifndef ASSERT_OFF
	// A stalled first stage keeps its word.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !ld_s2 |=> v_s1 && $stable(mag_s1) && $stable(neg_s1))
		else $error("front stage 1 lost its word during a stall");
`endif

endmodule

`default_nettype wire

// ----- src/jrci_interp.sv -----
`default_nettype none

// Interpolation within the segment: stages 4 to 6.
module jrci_interp import jrci_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  front_t  in_data,
	input  cfg_t    cfg,
	output logic    out_valid,
	input  logic    out_ready,
	output interp_t out_data
);

	localparam logic [PROD2_W:0] ROUND_HALF = (PROD2_W + 1)'(1) << (2 * FRAC_BITS - 1);

	logic ld_s4, ld_s5, ld_s6;
	logic v_s4, v_s5, v_s6;

	logic [PROD1_W-1:0] prod1_s4;
	logic [RECIP_W-1:0] recip_s4;
	logic [Y_W-1:0]     y0_s4;
	logic               neg_s4;
	logic               over_s4;
	logic [PROD2_W-1:0] prod2_s5;
	logic [Y_W-1:0]     y0_s5;
	logic               neg_s5;
	logic               over_s5;
	interp_t            data_s6;

	logic [PROD2_W:0]   rnd_sum;
	logic [Y_W-1:0]     y_c;

	assign ld_s6    = !v_s6 || out_ready;
	assign ld_s5    = !v_s5 || ld_s6;
	assign ld_s4    = !v_s4 || ld_s5;
	assign in_ready = ld_s4;

	// Above the last breakpoint the curve's top value is held.
	always_comb begin
		rnd_sum = {1'b0, prod2_s5} + ROUND_HALF;
		if (over_s5) begin
			y_c = CURVE_FIX[cfg.idx][TABLE_POINTS-1];
		end else begin
			y_c = y0_s5 + rnd_sum[2*FRAC_BITS +: Y_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld_s4) begin
				v_s4 <= in_valid;
			end
			if (ld_s5) begin
				v_s5 <= v_s4;
			end
			if (ld_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			prod1_s4 <= PROD1_W'(in_data.dy) * PROD1_W'(in_data.off);
			recip_s4 <= RECIP_FIX[in_data.seg];
			y0_s4    <= in_data.y0;
			neg_s4   <= in_data.neg;
			over_s4  <= in_data.over;
		end
		if (ld_s5) begin
			prod2_s5 <= PROD2_W'(prod1_s4) * PROD2_W'(recip_s4);
			y0_s5    <= y0_s4;
			neg_s5   <= neg_s4;
			over_s5  <= over_s4;
		end
		if (ld_s6) begin
			data_s6.neg <= neg_s5;
			data_s6.y   <= y_c;
		end
	end

	assign out_valid = v_s6;
	assign out_data  = data_s6;

`ifndef ASSERT_OFF
	// The shaped magnitude never passes full scale.
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> data_s6.y <= Y_W'(1 << FRAC_BITS))
		else $error("interpolated value above full scale");
`endif

endmodule

`default_nettype wire

// ----- src/jrci_scale.sv -----
`default_nettype none

// Gain, rounding, clamp and sign restore: stages 7 to 9.
module jrci_scale import jrci_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  interp_t             in_data,
	input  cfg_t                cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] out_data
);

	localparam logic [SCALED_W-1:0] RND_POS = SCALED_W'(1) << (GAIN_FRAC - 1);
	localparam logic [SCALED_W-1:0] RND_NEG = RND_POS + SCALED_W'(1);

	logic ld_s7, ld_s8, ld_s9;
	logic v_s7, v_s8, v_s9;

	logic signed [SCALED_W-1:0] p_s7;
	logic                       neg_s7;
	logic [ROUNDED_W-1:0]       m_s8;
	logic                       sign_s8;
	logic [SAMPLE_W-1:0]        data_s9;

	logic [SCALED_W-1:0]  mr_c;
	logic [Y_W-1:0]       top_c;
	logic [Y_W-1:0]       mc_c;
	logic [SAMPLE_W-1:0]  res_c;

	assign ld_s9    = !v_s9 || out_ready;
	assign ld_s8    = !v_s8 || ld_s9;
	assign ld_s7    = !v_s7 || ld_s8;
	assign in_ready = ld_s7;

	// Magnitude and round half away from zero in one add: -p + h = ~p + h + 1.
	always_comb begin
		if (p_s7[SCALED_W-1]) begin
			mr_c = ~p_s7 + RND_NEG;
		end else begin
			mr_c = p_s7 + RND_POS;
		end
	end

	always_comb begin
		top_c = CURVE_FIX[cfg.idx][TABLE_POINTS-1];
		if (m_s8 > ROUNDED_W'(top_c)) begin
			mc_c = top_c;
		end else begin
			mc_c = m_s8[Y_W-1:0];
		end
		if (!cfg.ok) begin
			res_c = '0;
		end else if (sign_s8) begin
			res_c = SAMPLE_W'(-{1'b0, mc_c});
		end else begin
			res_c = SAMPLE_W'({1'b0, mc_c});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (ld_s7) begin
				v_s7 <= in_valid;
			end
			if (ld_s8) begin
				v_s8 <= v_s7;
			end
			if (ld_s9) begin
				v_s9 <= v_s8;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s7) begin
			p_s7   <= cfg.gain * $signed({1'b0, in_data.y});
			neg_s7 <= in_data.neg;
		end
		if (ld_s8) begin
			m_s8    <= mr_c[SCALED_W-1:GAIN_FRAC];
			sign_s8 <= p_s7[SCALED_W-1] ^ neg_s7;
		end
		if (ld_s9) begin
			data_s9 <= res_c;
		end
	end

	assign out_valid = v_s9;
	assign out_data  = data_s9;

`ifndef ASSERT_OFF
	// A stalled stage 8 keeps its word until stage 9 is free to take it.
	a_s8_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && !ld_s9 |=> v_s8 && $stable(m_s8) && $stable(sign_s8))
		else $error("scale stage 8 lost its word during a stall");
`endif

endmodule

`default_nettype wire
